FILE: src/bic_pkg.sv
package bic_pkg;

  // sequencer modes, as seen on the result stream
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_HEAT  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_COLD_HEAT  = 3'd0;
  localparam logic [2:0] CFG_COLD_VENT  = 3'd1;
  localparam logic [2:0] CFG_WARM_HEAT  = 3'd2;
  localparam logic [2:0] CFG_WARM_VENT  = 3'd3;
  localparam logic [2:0] CFG_GAIN       = 3'd4;
  localparam logic [2:0] CFG_BAND       = 3'd5;
  localparam logic [2:0] CFG_SP_MIN     = 3'd6;
  localparam logic [2:0] CFG_SP_MAX     = 3'd7;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;

  // register reset values
  localparam logic [7:0]  RST_COLD_HEAT = 8'd42;
  localparam logic [7:0]  RST_COLD_VENT = 8'd36;
  localparam logic [7:0]  RST_WARM_HEAT = 8'd27;
  localparam logic [7:0]  RST_WARM_VENT = 8'd22;
  localparam logic [15:0] RST_GAIN      = 16'd3277;
  localparam logic [10:0] RST_BAND      = 11'd200;
  localparam logic [13:0] RST_SP_MIN    = 14'd4500;
  localparam logic [13:0] RST_SP_MAX    = 14'd8000;

  // temperature constants, 0.01 C units
  localparam int SWING       = 200;
  localparam int WATER_RISE  = 10;
  localparam int WATER_FALL  = 2;
  localparam int WATER_FLOOR = 2000;
  localparam int SAFE_MARGIN = 1;
  localparam int TEMP_RESET  = 4000;

  localparam int SP_BITS    = 14;  // setpoint width
  localparam int GAIN_BITS  = 16;  // Q0.16 sensor gain
  localparam int DIV_QBITS  = 14;  // scaled setpoint quotient width
  localparam int OUT_TEMP_BITS = 16;

endpackage

FILE: src/bic_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module bic_serial_mul #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int CNT_W = (BW > 1) ? $clog2(BW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BW - 1);

  logic [AW-1:0]    mcand;
  logic [AW-1:0]    acc_hi;
  logic [BW-1:0]    acc_lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [AW:0]      sum;

  assign sum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      acc_hi <= '0;
      acc_lo <= b;
    end else if (busy) begin
      acc_hi <= sum[AW:1];
      acc_lo <= {sum[0], acc_lo[BW-1:1]};
    end
  end

  assign product = {acc_hi, acc_lo};

endmodule

FILE: src/bic_const_div.sv
// Restoring divider by the constant 2^SW-1, one quotient bit per cycle.
// Caller guarantees x < (2^SW-1) * 2^DIV_QBITS, so the top slice of x
// is already a valid partial remainder.
module bic_const_div import bic_pkg::*; #(
  parameter int SW = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [SW+DIV_QBITS-1:0] x,
  output logic                    done,
  output logic [DIV_QBITS-1:0]    quot
);

  localparam logic [SW:0] DIVISOR = {1'b0, {SW{1'b1}}};
  localparam int CNT_W = $clog2(DIV_QBITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_QBITS - 1);

  logic [SW-1:0]        rem;
  logic [DIV_QBITS-1:0] qs;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [SW:0]          trial;
  logic [SW:0]          diff;
  logic                 ge;

  assign trial = {rem, qs[DIV_QBITS-1]};
  assign ge    = (trial >= DIVISOR);
  assign diff  = trial - DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= x[SW+DIV_QBITS-1:DIV_QBITS];
      qs  <= x[DIV_QBITS-1:0];
    end else if (busy) begin
      rem <= ge ? diff[SW-1:0] : trial[SW-1:0];
      qs  <= {qs[DIV_QBITS-2:0], ge};
    end
  end

  assign quot = qs;

endmodule

FILE: src/burner_ignition_and_hysteresis_control_top.sv
// Burner ignition sequencer with hysteresis thermostat. One input transaction
// is one one-second tick (demand level plus a setpoint sample); each tick
// returns exactly one result transaction with mode, burner, vent, water and
// probe temperatures and the scaled setpoint. Temperatures are signed 0.01 C
// values saturated to TEMP_BITS and reported as their low 16 bits. The setpoint
// product runs through a 16-step shift-add multiplier, the divide by full scale
// through a 14-step restoring divider, and while heating the probe lag update
// reuses the same multiplier for another 16 steps. One tick is in flight at a
// time; a finished result sits in the output register so the next tick can
// start while it waits. The user must write configuration through the cfg port
// only while no tick is in progress; the block itself does not enforce this.
module burner_ignition_and_hysteresis_control_top import bic_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int TEMP_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input tick: [0] demand, [SAMPLE_BITS:1] setpoint_sample, rest zero
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] s_tdata,
  // result: [1:0] mode, [2] burner_lit, [3] vent_is_open,
  // [19:4] water_level_temp, [35:20] probe_temp, [49:36] setpoint_now
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [55:0]                           m_tdata,
  // register write port
  input  logic                                  cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
  input  logic [CFG_DATA_BITS-1:0]              cfg_data
);

  // TW: temperature width, at least the 16-bit output width
  localparam int TW = (TEMP_BITS > OUT_TEMP_BITS) ? TEMP_BITS : OUT_TEMP_BITS;
  localparam int DW = TW + 1;        // |delta| magnitude width
  localparam int CW = DW + 2;        // signed working width
  localparam int PW = DW + GAIN_BITS;
  localparam int XW = SAMPLE_BITS + DIV_QBITS;

  localparam logic [XW-1:0] HALF_FULL = XW'((64'd1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [CW-1:0] T_MAX = CW'((64'sd1 <<< (TEMP_BITS - 1)) - 1);
  localparam logic signed [CW-1:0] T_MIN = -T_MAX - CW'(1);
  localparam logic signed [CW-1:0] SWING_C = CW'(SWING);
  localparam logic signed [CW-1:0] MARGIN_C = CW'(SAFE_MARGIN);
  localparam logic signed [CW-1:0] RISE_C = CW'(WATER_RISE);
  localparam logic signed [TEMP_BITS-1:0] FALL_C = TEMP_BITS'(WATER_FALL);
  localparam logic signed [TEMP_BITS-1:0] FLOOR_C = TEMP_BITS'(WATER_FLOOR);
  localparam logic signed [TEMP_BITS-1:0] TRESET_C = TEMP_BITS'(TEMP_RESET);
  localparam logic [PW:0] ROUND_C = (PW + 1)'(32768);

  // tick sequencing states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;  // sample * |max-min|
  localparam logic [2:0] ST_DIV  = 3'd2;  // / full scale
  localparam logic [2:0] ST_SEQ  = 3'd3;  // ignition sequencer step
  localparam logic [2:0] ST_MUL2 = 3'd4;  // probe lag product + hysteresis
  localparam logic [2:0] ST_FIN  = 3'd5;  // water update, result out

  function automatic logic signed [TEMP_BITS-1:0] sat_t(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    begin
      r = v;
      if (v > T_MAX) r = T_MAX;
      else if (v < T_MIN) r = T_MIN;
      return r[TEMP_BITS-1:0];
    end
  endfunction

  // configuration registers
  logic [7:0]  cold_heat_delay, cold_vent_delay, warm_heat_delay, warm_vent_delay;
  logic [15:0] sensor_gain;
  logic [10:0] hysteresis_band;
  logic [13:0] setpoint_min, setpoint_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      cold_heat_delay <= RST_COLD_HEAT;
      cold_vent_delay <= RST_COLD_VENT;
      warm_heat_delay <= RST_WARM_HEAT;
      warm_vent_delay <= RST_WARM_VENT;
      sensor_gain     <= RST_GAIN;
      hysteresis_band <= RST_BAND;
      setpoint_min    <= RST_SP_MIN;
      setpoint_max    <= RST_SP_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLD_HEAT: cold_heat_delay <= cfg_data[7:0];
        CFG_COLD_VENT: cold_vent_delay <= cfg_data[7:0];
        CFG_WARM_HEAT: warm_heat_delay <= cfg_data[7:0];
        CFG_WARM_VENT: warm_vent_delay <= cfg_data[7:0];
        CFG_GAIN:      sensor_gain     <= cfg_data[15:0];
        CFG_BAND:      hysteresis_band <= cfg_data[10:0];
        CFG_SP_MIN:    setpoint_min    <= cfg_data[13:0];
        CFG_SP_MAX:    setpoint_max    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic [2:0]                  state;
  logic [1:0]                  mode_reg;
  logic                        last_demand, cold_start, vent_flag, burner_flag;
  logic [7:0]                  start_seconds;
  logic signed [TEMP_BITS-1:0] water_reg, probe_reg;
  logic [SP_BITS-1:0]          target;
  logic                        dem_reg, span_neg, delta_neg;

  // output register
  logic [1:0]                  out_mode;
  logic                        out_burner, out_vent;
  logic [OUT_TEMP_BITS-1:0]    out_water, out_probe;
  logic [SP_BITS-1:0]          out_sp;

  // serial units
  logic          mul_start, mul_done;
  logic [DW-1:0] mul_a;
  logic [GAIN_BITS-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic          div_start, div_done;
  logic [XW-1:0] div_x;
  logic [DIV_QBITS-1:0] div_q;

  bic_serial_mul #(.AW(DW), .BW(GAIN_BITS)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  bic_const_div #(.SW(SAMPLE_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .done  (div_done),
    .quot  (div_q)
  );

  logic in_fire;
  logic in_demand;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic signed [SP_BITS:0] span;
  logic [SP_BITS-1:0] span_mag;

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign in_demand = s_tdata[0];
  assign in_sample = s_tdata[SAMPLE_BITS:1];
  assign span      = $signed({1'b0, setpoint_max}) - $signed({1'b0, setpoint_min});
  assign span_mag  = span[SP_BITS] ? SP_BITS'(-span) : span[SP_BITS-1:0];

  assign div_start = (state == ST_MUL1) && mul_done;
  assign div_x     = mul_prod[XW-1:0] + HALF_FULL;

  // sequencer step, evaluated in ST_SEQ
  logic [1:0]                  sq_mode;
  logic                        sq_cold, sq_vent, sq_burner;
  logic [7:0]                  sq_secs;
  logic signed [TEMP_BITS-1:0] sq_probe;
  logic signed [CW-1:0]        tgt_s, band_s, sq_delta;
  logic [DW-1:0]               sq_delta_mag;

  assign tgt_s  = CW'($signed({1'b0, target}));
  assign band_s = CW'($signed({1'b0, hysteresis_band}));

  always_comb begin
    logic [7:0]           vd, hd;
    logic [11:0]          band_up;
    logic signed [CW-1:0] safe, base, clamp, ref_t;
    sq_mode   = mode_reg;
    sq_cold   = cold_start;
    sq_vent   = vent_flag;
    sq_burner = burner_flag;
    sq_secs   = start_seconds;
    sq_probe  = probe_reg;
    vd    = cold_start ? cold_vent_delay : warm_vent_delay;
    hd    = cold_start ? cold_heat_delay : warm_heat_delay;
    // half band rounded up, one bit wider so a full-scale band cannot wrap
    band_up = {1'b0, hysteresis_band} + 12'd1;
    safe  = tgt_s - CW'($signed({1'b0, band_up[11:1]})) - MARGIN_C;
    base  = cold_start ? CW'(water_reg) : CW'(probe_reg);
    clamp = (base < safe) ? base : safe;
    case (mode_reg)
      MODE_START: begin
        if (!dem_reg) begin
          sq_mode = MODE_OFF;
          sq_vent = 1'b0;
        end else begin
          if (start_seconds != 8'hFF) sq_secs = start_seconds + 8'd1;
          if (sq_secs >= vd) sq_vent = 1'b1;
          if (sq_secs >= hd) begin
            // fire: pull the probe below the lower band edge
            sq_mode   = MODE_HEAT;
            sq_burner = 1'b1;
            sq_probe  = sat_t(clamp);
          end
        end
      end
      MODE_HEAT: begin
        if (!dem_reg) begin
          sq_mode   = MODE_OFF;
          sq_burner = 1'b0;
          sq_vent   = 1'b0;
        end
      end
      default: begin
        // off, and the unused code: only a demand rise starts a cold sequence
        sq_mode = MODE_OFF;
        if (dem_reg && !last_demand) begin
          sq_mode = MODE_START;
          sq_secs = 8'd0;
          sq_cold = 1'b1;
          sq_vent = 1'b0;
        end
      end
    endcase
    if (sq_mode != MODE_HEAT) sq_burner = 1'b0;
    ref_t        = sq_burner ? tgt_s + SWING_C : tgt_s - SWING_C;
    sq_delta     = ref_t - CW'(sq_probe);
    sq_delta_mag = sq_delta[CW-1] ? DW'(-sq_delta) : DW'(sq_delta);
  end

  assign mul_start = in_fire || ((state == ST_SEQ) && (sq_mode == MODE_HEAT));
  assign mul_a     = (state == ST_IDLE) ? DW'(span_mag) : sq_delta_mag;
  assign mul_b     = (state == ST_IDLE) ? GAIN_BITS'(in_sample) : sensor_gain;

  // probe lag update and hysteresis, evaluated on the second product
  logic [PW:0]                 rnd_sum;
  logic signed [CW-1:0]        step_q, probe_new_w;
  logic signed [TEMP_BITS-1:0] probe_new;
  logic                        hy_off, hy_relight;

  assign rnd_sum     = {1'b0, mul_prod} + ROUND_C;
  assign step_q      = CW'(rnd_sum[PW:GAIN_BITS]);
  assign probe_new_w = delta_neg ? CW'(probe_reg) - step_q : CW'(probe_reg) + step_q;
  assign probe_new   = sat_t(probe_new_w);
  assign hy_off      = burner_flag && ((CW'(probe_new) <<< 1) >= ((tgt_s <<< 1) + band_s));
  assign hy_relight  = !burner_flag && ((CW'(probe_new) <<< 1) <= ((tgt_s <<< 1) - band_s));

  // water: rise while lit, slow fall above the floor
  logic signed [TEMP_BITS-1:0] water_next;
  always_comb begin
    water_next = water_reg;
    if (burner_flag) water_next = sat_t(CW'(water_reg) + RISE_C);
    else if (water_reg > FLOOR_C) water_next = water_reg - FALL_C;
  end

  logic out_load;
  logic signed [TW-1:0] water_x, probe_x;
  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);
  assign water_x  = TW'(water_next);
  assign probe_x  = TW'(probe_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode_reg      <= MODE_OFF;
      last_demand   <= 1'b0;
      start_seconds <= 8'd0;
      cold_start    <= 1'b0;
      vent_flag     <= 1'b0;
      burner_flag   <= 1'b0;
      water_reg     <= TRESET_C;
      probe_reg     <= TRESET_C;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) state <= ST_MUL1;
        end
        ST_MUL1: begin
          if (mul_done) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state <= ST_SEQ;
        end
        ST_SEQ: begin
          mode_reg      <= sq_mode;
          cold_start    <= sq_cold;
          vent_flag     <= sq_vent;
          burner_flag   <= sq_burner;
          start_seconds <= sq_secs;
          probe_reg     <= sq_probe;
          last_demand   <= dem_reg;
          state         <= (sq_mode == MODE_HEAT) ? ST_MUL2 : ST_FIN;
        end
        ST_MUL2: begin
          if (mul_done) begin
            probe_reg <= probe_new;
            if (hy_off) begin
              burner_flag <= 1'b0;
            end else if (hy_relight) begin
              // warm relight request
              mode_reg      <= MODE_START;
              cold_start    <= 1'b0;
              start_seconds <= 8'd0;
              vent_flag     <= 1'b0;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            water_reg <= water_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result valid: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dem_reg  <= in_demand;
      span_neg <= span[SP_BITS];
    end
    if (div_done) begin
      target <= span_neg ? setpoint_min - div_q : setpoint_min + div_q;
    end
    if (state == ST_SEQ) delta_neg <= sq_delta[CW-1];
    if (out_load) begin
      out_mode   <= mode_reg;
      out_burner <= burner_flag;
      out_vent   <= vent_flag;
      out_water  <= water_x[OUT_TEMP_BITS-1:0];
      out_probe  <= probe_x[OUT_TEMP_BITS-1:0];
      out_sp     <= target;
    end
  end

  assign m_tdata = {6'd0, out_sp, out_probe, out_water, out_vent, out_burner, out_mode};

endmodule
